// ===== hdl/dcrb_pkg.sv =====
package dcrb_pkg;

    localparam int DEF_NUM_CHANNELS = 6;
    localparam int CHANNEL_STRIDE   = 32;
    localparam int IRQ_W            = 6;
    localparam int CHN_IDX_W        = 3;

    // Request codes
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_DONE  = 2'd2;
    localparam logic [1:0] REQ_NOP   = 2'd3;

    // Access sizes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_RSVD = 2'd3;

    // Register index inside a channel window (offset bits 4..2)
    localparam logic [2:0] RIDX_DEVADDR = 3'd0;
    localparam logic [2:0] RIDX_SET     = 3'd1;
    localparam logic [2:0] RIDX_CLR     = 3'd2;
    localparam logic [2:0] RIDX_STATUS  = 3'd3;
    localparam logic [2:0] RIDX_SA_A    = 3'd4;
    localparam logic [2:0] RIDX_CNT_A   = 3'd5;
    localparam logic [2:0] RIDX_SA_B    = 3'd6;
    localparam logic [2:0] RIDX_CNT_B   = 3'd7;

    // Control/status bit positions
    localparam int BIT_RUN   = 0;
    localparam int BIT_IE    = 1;
    localparam int BIT_ERROR = 2;
    localparam int BIT_DONEA = 3;
    localparam int BIT_STRTA = 4;
    localparam int BIT_DONEB = 5;
    localparam int BIT_STRTB = 6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  offset;
        logic [1:0]  access_size;
        logic [31:0] write_data;
        logic [2:0]  done_channel;
        logic        done_buffer_b;
        logic        claim_a;
        logic        claim_b;
    } req_t;

    typedef struct packed {
        logic [31:0] dev_addr;
        logic [31:0] ctrl;
        logic [31:0] sa_a;
        logic [31:0] cnt_a;
        logic [31:0] sa_b;
        logic [31:0] cnt_b;
        logic        busy_a;
        logic        busy_b;
    } chan_t;

    typedef struct packed {
        logic                 we;
        logic [CHN_IDX_W-1:0] ch;
        chan_t                data;
    } chan_upd_t;

    typedef struct packed {
        logic [31:0]          read_data;
        logic                 access_error;
        logic [CHN_IDX_W-1:0] kick_channel;
        logic                 kick_a;
        logic                 kick_b;
    } rsp_t;

endpackage

// ===== hdl/dcrb_regs.sv =====
module dcrb_regs #(
    parameter int NUM_CHANNELS = dcrb_pkg::DEF_NUM_CHANNELS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [dcrb_pkg::CHN_IDX_W-1:0]    sel_ch,
    output dcrb_pkg::chan_t                   sel_state,
    input  dcrb_pkg::chan_upd_t               upd,
    output logic [dcrb_pkg::IRQ_W-1:0]        irq_lines
);
    import dcrb_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CHN_IDX_W:0] NUM_L = (CHN_IDX_W + 1)'(NUM_CHANNELS);

    chan_t chan_reg [NUM_CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                chan_reg[i] <= '0;
            end
        end
        else if (upd.we)
        begin
            chan_reg[upd.ch[CH_W-1:0]] <= upd.data;
        end
    end

    // A channel number past the last channel reads as an all-zero channel.
    always_comb
    begin
        if ({1'b0, sel_ch} < NUM_L)
        begin
            sel_state = chan_reg[sel_ch[CH_W-1:0]];
        end
        else
        begin
            sel_state = '0;
        end
    end

    for (genvar g = 0; g < IRQ_W; g++)
    begin : g_irq
        if (g < NUM_CHANNELS)
        begin : g_live
            assign irq_lines[g] = chan_reg[g].ctrl[BIT_IE] &
                                  (chan_reg[g].ctrl[BIT_DONEA] |
                                   chan_reg[g].ctrl[BIT_DONEB] |
                                   chan_reg[g].ctrl[BIT_ERROR]);
        end
        else
        begin : g_none
            assign irq_lines[g] = 1'b0;
        end
    end

endmodule

// ===== hdl/dcrb_access.sv =====
module dcrb_access #(
    parameter int NUM_CHANNELS = dcrb_pkg::DEF_NUM_CHANNELS
) (
    input  logic                              rq_valid,
    input  dcrb_pkg::req_t                    rq,
    output logic [dcrb_pkg::CHN_IDX_W-1:0]    sel_ch,
    input  dcrb_pkg::chan_t                   cur,
    output dcrb_pkg::chan_upd_t               upd,
    output dcrb_pkg::rsp_t                    rsp
);
    import dcrb_pkg::*;

    localparam logic [8:0]           REGION = 9'(NUM_CHANNELS * CHANNEL_STRIDE);
    localparam logic [CHN_IDX_W:0]   NUM_L  = (CHN_IDX_W + 1)'(NUM_CHANNELS);

    logic                 is_acc;
    logic                 out_rng;
    logic                 unaligned;
    logic                 acc_ok;
    logic                 dch_ok;
    logic [CHN_IDX_W-1:0] acc_ch;
    logic [2:0]           ridx;
    logic [4:0]           shift;
    logic [31:0]          lane;
    logic [31:0]          cur_val;
    logic [31:0]          merged;
    logic [31:0]          fresh;
    logic [31:0]          ctrl_set;
    logic                 offer_a;
    logic                 offer_b;
    logic                 rx;
    chan_t                nxt;

    assign is_acc    = (rq.req_type == REQ_READ) || (rq.req_type == REQ_WRITE);
    assign out_rng   = {1'b0, rq.offset} >= REGION;
    assign unaligned = rq.access_size[1] && (rq.offset[1:0] != 2'b00);
    assign acc_ok    = rq_valid && is_acc && !out_rng && !unaligned;
    assign dch_ok    = {1'b0, rq.done_channel} < NUM_L;
    assign acc_ch    = rq.offset[7:5];
    assign ridx      = rq.offset[4:2];
    assign sel_ch    = (rq.req_type == REQ_DONE) ? rq.done_channel : acc_ch;
    assign rx        = cur.dev_addr[0];

    always_comb
    begin
        case (rq.access_size)
            SIZE_BYTE:
            begin
                shift = {rq.offset[1:0], 3'b000};
                lane  = 32'h0000_00FF;
            end
            SIZE_HALF:
            begin
                shift = {rq.offset[1], 4'b0000};
                lane  = 32'h0000_FFFF;
            end
            default:
            begin
                shift = 5'd0;
                lane  = 32'hFFFF_FFFF;
            end
        endcase
    end

    always_comb
    begin
        case (ridx)
            RIDX_DEVADDR: cur_val = cur.dev_addr;
            RIDX_STATUS:  cur_val = cur.ctrl;
            RIDX_SA_A:    cur_val = cur.sa_a;
            RIDX_CNT_A:   cur_val = cur.cnt_a;
            RIDX_SA_B:    cur_val = cur.sa_b;
            RIDX_CNT_B:   cur_val = cur.cnt_b;
            default:      cur_val = 32'd0;
        endcase
    end

    assign merged = (cur_val & ~(lane << shift)) | ((rq.write_data & lane) << shift);

    // Write-one-to-set port: a start bit that goes from clear to set clears its done bit, and
    // offers an idle buffer when the channel runs; a rising RUN offers every pending start.
    always_comb
    begin
        fresh    = merged & ~cur.ctrl;
        ctrl_set = cur.ctrl | merged;
        if (fresh[BIT_STRTA])
        begin
            ctrl_set[BIT_DONEA] = 1'b0;
        end
        if (fresh[BIT_STRTB])
        begin
            ctrl_set[BIT_DONEB] = 1'b0;
        end
        offer_a = ctrl_set[BIT_RUN] && !cur.busy_a &&
                  (fresh[BIT_RUN] ? ctrl_set[BIT_STRTA] : fresh[BIT_STRTA]);
        offer_b = ctrl_set[BIT_RUN] && !cur.busy_b &&
                  (fresh[BIT_RUN] ? ctrl_set[BIT_STRTB] : fresh[BIT_STRTB]);
    end

    always_comb
    begin
        nxt              = cur;
        upd.we           = 1'b0;
        rsp.read_data    = 32'd0;
        rsp.access_error = rq_valid && is_acc && out_rng;
        rsp.kick_a       = 1'b0;
        rsp.kick_b       = 1'b0;
        rsp.kick_channel = '0;

        if (acc_ok && (rq.req_type == REQ_READ))
        begin
            rsp.read_data = (cur_val >> shift) & lane;
        end

        if (acc_ok && (rq.req_type == REQ_WRITE))
        begin
            upd.we = 1'b1;
            case (ridx)
                RIDX_DEVADDR: nxt.dev_addr = merged;
                RIDX_SA_A:    nxt.sa_a     = merged;
                RIDX_CNT_A:   nxt.cnt_a    = merged;
                RIDX_SA_B:    nxt.sa_b     = merged;
                RIDX_CNT_B:   nxt.cnt_b    = merged;
                RIDX_CLR:     nxt.ctrl     = cur.ctrl & ~merged;
                RIDX_SET:
                begin
                    nxt.ctrl = ctrl_set;
                    if (offer_a)
                    begin
                        rsp.kick_a = 1'b1;
                        if (rq.claim_a)
                        begin
                            nxt.busy_a = 1'b1;
                        end
                        else if (!rx)
                        begin
                            nxt.ctrl[BIT_DONEA] = 1'b1;
                        end
                    end
                    if (offer_b)
                    begin
                        rsp.kick_b = 1'b1;
                        if (rq.claim_b)
                        begin
                            nxt.busy_b = 1'b1;
                        end
                        else if (!rx)
                        begin
                            nxt.ctrl[BIT_DONEB] = 1'b1;
                        end
                    end
                    if (offer_a || offer_b)
                    begin
                        rsp.kick_channel = acc_ch;
                    end
                end
                default: upd.we = 1'b0;
            endcase
        end

        if (rq_valid && (rq.req_type == REQ_DONE) && dch_ok)
        begin
            upd.we = 1'b1;
            if (rq.done_buffer_b)
            begin
                nxt.ctrl[BIT_STRTB] = 1'b0;
                nxt.ctrl[BIT_DONEB] = 1'b1;
                nxt.busy_b          = 1'b0;
            end
            else
            begin
                nxt.ctrl[BIT_STRTA] = 1'b0;
                nxt.ctrl[BIT_DONEA] = 1'b1;
                nxt.busy_a          = 1'b0;
            end
        end

        upd.ch   = sel_ch;
        upd.data = nxt;
    end

endmodule

// ===== hdl/dma_channel_register_block_unit.sv =====
// Channel   Direction  Handshake            Words
// request   in         start / busy         req_type, offset, access_size, write_data,
//                                           done_channel, done_buffer_b, claim_a, claim_b
// result    out        done (one-cycle)     read_data, access_error, kick_channel,
//                                           kick_a, kick_b, irq_lines
//
// A request word is registered at the edge that accepts it, is decoded and applied to
// the channel registers during the next cycle, and its result is shown with done in the
// cycle after that. busy stays low, so one word is taken every cycle. Reset clears every
// channel register and the in-flight flags. The receiver cannot stall;
// irq_lines reflects the state left by the word on show.
module dma_channel_register_block_unit #(
    parameter int NUM_CHANNELS = dcrb_pkg::DEF_NUM_CHANNELS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     req_type,
    input  logic [7:0]                     offset,
    input  logic [1:0]                     access_size,
    input  logic [31:0]                    write_data,
    input  logic [2:0]                     done_channel,
    input  logic                           done_buffer_b,
    input  logic                           claim_a,
    input  logic                           claim_b,
    output logic                           done,
    output logic [31:0]                    read_data,
    output logic                           access_error,
    output logic [2:0]                     kick_channel,
    output logic                           kick_a,
    output logic                           kick_b,
    output logic [dcrb_pkg::IRQ_W-1:0]     irq_lines
);
    import dcrb_pkg::*;

    logic                 valid_reg;
    req_t                 rq_reg;
    req_t                 rq_next;
    logic                 done_reg;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;
    logic [CHN_IDX_W-1:0] sel_ch;
    chan_t                sel_state;
    chan_upd_t            upd;

    assign busy = 1'b0;

    assign rq_next = '{req_type:      req_type,
                       offset:        offset,
                       access_size:   access_size,
                       write_data:    write_data,
                       done_channel:  done_channel,
                       done_buffer_b: done_buffer_b,
                       claim_a:       claim_a,
                       claim_b:       claim_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            rq_reg <= rq_next;
        end
        if (valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    dcrb_access #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_access (
        .rq_valid (valid_reg),
        .rq       (rq_reg),
        .sel_ch   (sel_ch),
        .cur      (sel_state),
        .upd      (upd),
        .rsp      (rsp_next)
    );

    dcrb_regs #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .sel_ch    (sel_ch),
        .sel_state (sel_state),
        .upd       (upd),
        .irq_lines (irq_lines)
    );

    assign done         = done_reg;
    assign read_data    = rsp_reg.read_data;
    assign access_error = rsp_reg.access_error;
    assign kick_channel = rsp_reg.kick_channel;
    assign kick_a       = rsp_reg.kick_a;
    assign kick_b       = rsp_reg.kick_b;

endmodule

// ===== hdl/dcrb_checker.sv =====
module dcrb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [1:0]                     req_type,
    input logic                           done,
    input logic [31:0]                    read_data,
    input logic                           access_error,
    input logic [2:0]                     kick_channel,
    input logic                           kick_a,
    input logic                           kick_b
);
    import dcrb_pkg::*;

    // Every accepted word yields exactly one result, once it has passed the request and result registers.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(start && !busy && rst_n, 2) && $past(rst_n)) |-> done)
        else $error("accepted word produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without an accepted word");

    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && access_error) |->
            (read_data == 32'd0) && !kick_a && !kick_b &&
            ($past(req_type, 2) == REQ_READ || $past(req_type, 2) == REQ_WRITE))
        else $error("flagged access returned data or kicked a buffer");

    a_kick_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (kick_a || kick_b)) |-> ($past(req_type, 2) == REQ_WRITE))
        else $error("buffer kicked by a word that is not a write");

    a_idle_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !kick_a && !kick_b) |-> (kick_channel == 3'd0))
        else $error("kick channel set with nothing offered");

endmodule

bind dma_channel_register_block_unit dcrb_checker u_dcrb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .done         (done),
    .read_data    (read_data),
    .access_error (access_error),
    .kick_channel (kick_channel),
    .kick_a       (kick_a),
    .kick_b       (kick_b)
);

// ===== bench/dma_channel_register_block_checker.sv =====
`timescale 1ns / 1ps

module dma_channel_register_block_checker #(
    parameter int NCH = dcrb_pkg::DEF_NUM_CHANNELS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [1:0]                     req_type,
    input  logic [7:0]                     offset,
    input  logic [1:0]                     access_size,
    input  logic [31:0]                    write_data,
    input  logic [2:0]                     done_channel,
    input  logic                           done_buffer_b,
    input  logic                           claim_a,
    input  logic                           claim_b,
    input  logic                           done,
    input  logic [31:0]                    read_data,
    input  logic                           access_error,
    input  logic [2:0]                     kick_channel,
    input  logic                           kick_a,
    input  logic                           kick_b,
    input  logic [dcrb_pkg::IRQ_W-1:0]     irq_lines,
    output int                             fail_count,
    output int                             outstanding
);
    import dcrb_pkg::*;

    typedef struct packed {
        logic [31:0]      read_data;
        logic             access_error;
        logic [2:0]       kick_channel;
        logic             kick_a;
        logic             kick_b;
        logic [IRQ_W-1:0] irq_lines;
    } outcome_t;

    logic [31:0] dev_addr_m [NCH];
    logic [31:0] ctrl_m     [NCH];
    logic [31:0] sa_a_m     [NCH];
    logic [31:0] cnt_a_m    [NCH];
    logic [31:0] sa_b_m     [NCH];
    logic [31:0] cnt_b_m    [NCH];
    logic        busy_a_m   [NCH];
    logic        busy_b_m   [NCH];

    outcome_t pending_outcomes [$];

    function automatic void enqueue_outcome(input outcome_t o);
        pending_outcomes = {pending_outcomes, o};
    endfunction

    function automatic logic [31:0] reg_value(input int c, input logic [2:0] ridx);
        case (ridx)
            RIDX_DEVADDR: return dev_addr_m[c];
            RIDX_STATUS:  return ctrl_m[c];
            RIDX_SA_A:    return sa_a_m[c];
            RIDX_CNT_A:   return cnt_a_m[c];
            RIDX_SA_B:    return sa_b_m[c];
            RIDX_CNT_B:   return cnt_b_m[c];
            default:      return 32'd0;
        endcase
    endfunction

    function automatic void apply_write(input int c, input logic [2:0] ridx,
                                        input logic [31:0] v, input logic ca,
                                        input logic cb, output logic ka, output logic kb);
        logic [31:0] fresh;
        logic [31:0] offer;
        logic        rx;
        ka = 1'b0;
        kb = 1'b0;
        case (ridx)
            RIDX_DEVADDR: dev_addr_m[c] = v;
            RIDX_SA_A:    sa_a_m[c] = v;
            RIDX_CNT_A:   cnt_a_m[c] = v;
            RIDX_SA_B:    sa_b_m[c] = v;
            RIDX_CNT_B:   cnt_b_m[c] = v;
            RIDX_CLR:     ctrl_m[c] = ctrl_m[c] & ~v;
            RIDX_SET:
            begin
                fresh = v & ~ctrl_m[c];
                ctrl_m[c] = ctrl_m[c] | v;
                if (fresh[BIT_STRTA])
                    ctrl_m[c][BIT_DONEA] = 1'b0;
                if (fresh[BIT_STRTB])
                    ctrl_m[c][BIT_DONEB] = 1'b0;
                if (ctrl_m[c][BIT_RUN])
                begin
                    // A rising RUN offers every pending start, otherwise only new ones.
                    offer = fresh[BIT_RUN] ? ctrl_m[c] : fresh;
                    rx = dev_addr_m[c][0];
                    if (offer[BIT_STRTA] && !busy_a_m[c])
                    begin
                        ka = 1'b1;
                        if (ca)
                            busy_a_m[c] = 1'b1;
                        else if (!rx)
                            ctrl_m[c][BIT_DONEA] = 1'b1;
                    end
                    if (offer[BIT_STRTB] && !busy_b_m[c])
                    begin
                        kb = 1'b1;
                        if (cb)
                            busy_b_m[c] = 1'b1;
                        else if (!rx)
                            ctrl_m[c][BIT_DONEB] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic outcome_t predict_outcome(input logic [1:0] rq, input logic [7:0] off,
                                                 input logic [1:0] sz, input logic [31:0] wd,
                                                 input logic [2:0] dch, input logic dbuf,
                                                 input logic ca, input logic cb);
        outcome_t    o;
        int          c;
        int          shift;
        logic [2:0]  ridx;
        logic [31:0] lane;
        logic [31:0] cur;
        logic [31:0] v;
        logic        wide;
        logic        ka;
        logic        kb;
        o = '0;
        if (rq == REQ_READ || rq == REQ_WRITE)
        begin
            if (int'(off) >= NCH * CHANNEL_STRIDE)
                o.access_error = 1'b1;
            else
            begin
                c = int'(off[7:5]);
                ridx = off[4:2];
                wide = (sz != SIZE_BYTE) && (sz != SIZE_HALF);
                // An unaligned word access does nothing and raises no error.
                if (!(wide && off[1:0] != 2'b00))
                begin
                    if (wide)
                    begin
                        shift = 0;
                        lane = 32'hFFFF_FFFF;
                    end
                    else if (sz == SIZE_HALF)
                    begin
                        shift = off[1] ? 16 : 0;
                        lane = 32'h0000_FFFF;
                    end
                    else
                    begin
                        shift = 8 * int'(off[1:0]);
                        lane = 32'h0000_00FF;
                    end
                    cur = reg_value(c, ridx);
                    if (rq == REQ_READ)
                        o.read_data = (cur >> shift) & lane;
                    else
                    begin
                        v = (cur & ~(lane << shift)) | ((wd & lane) << shift);
                        apply_write(c, ridx, v, ca, cb, ka, kb);
                        o.kick_a = ka;
                        o.kick_b = kb;
                        if (ka || kb)
                            o.kick_channel = off[7:5];
                    end
                end
            end
        end
        else if (rq == REQ_DONE)
        begin
            if (int'(dch) < NCH)
            begin
                c = int'(dch);
                if (dbuf)
                begin
                    ctrl_m[c][BIT_STRTB] = 1'b0;
                    ctrl_m[c][BIT_DONEB] = 1'b1;
                    busy_b_m[c] = 1'b0;
                end
                else
                begin
                    ctrl_m[c][BIT_STRTA] = 1'b0;
                    ctrl_m[c][BIT_DONEA] = 1'b1;
                    busy_a_m[c] = 1'b0;
                end
            end
        end
        for (int n = 0; n < NCH && n < IRQ_W; n++)
            o.irq_lines[n] = ctrl_m[n][BIT_IE] &&
                (ctrl_m[n][BIT_DONEA] || ctrl_m[n][BIT_DONEB] || ctrl_m[n][BIT_ERROR]);
        return o;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            for (int n = 0; n < NCH; n++)
            begin
                dev_addr_m[n] = '0;
                ctrl_m[n] = '0;
                sa_a_m[n] = '0;
                cnt_a_m[n] = '0;
                sa_b_m[n] = '0;
                cnt_b_m[n] = '0;
                busy_a_m[n] = 1'b0;
                busy_b_m[n] = 1'b0;
            end
            pending_outcomes.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $error("result word arrived with no prediction waiting");
                    fail_count++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    check_field("read_data", want.read_data, read_data);
                    check_field("access_error", 32'(want.access_error), 32'(access_error));
                    check_field("kick_channel", 32'(want.kick_channel), 32'(kick_channel));
                    check_field("kick_a", 32'(want.kick_a), 32'(kick_a));
                    check_field("kick_b", 32'(want.kick_b), 32'(kick_b));
                    check_field("irq_lines", 32'(want.irq_lines), 32'(irq_lines));
                end
            end
            if (start && !busy)
                enqueue_outcome(predict_outcome(req_type, offset, access_size,
                    write_data, done_channel, done_buffer_b, claim_a, claim_b));
            outstanding = pending_outcomes.size();
        end
    end

endmodule

// ===== bench/dma_channel_register_block_unit_test.sv =====
`timescale 1ns / 1ps

module dma_channel_register_block_unit_test;
    import dcrb_pkg::*;

    localparam int NCH = DEF_NUM_CHANNELS;
    localparam int RANDOM_WORDS = 1400;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           req_type;
    logic [7:0]           offset;
    logic [1:0]           access_size;
    logic [31:0]          write_data;
    logic [2:0]           done_channel;
    logic                 done_buffer_b;
    logic                 claim_a;
    logic                 claim_b;
    logic                 done;
    logic [31:0]          read_data;
    logic                 access_error;
    logic [2:0]           kick_channel;
    logic                 kick_a;
    logic                 kick_b;
    logic [IRQ_W-1:0]     irq_lines;
    int                   fail_count;
    int                   outstanding;
    logic                 gapless;

    dma_channel_register_block_unit #(.NUM_CHANNELS(NCH)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .offset(offset), .access_size(access_size),
        .write_data(write_data), .done_channel(done_channel),
        .done_buffer_b(done_buffer_b), .claim_a(claim_a), .claim_b(claim_b),
        .done(done), .read_data(read_data), .access_error(access_error),
        .kick_channel(kick_channel), .kick_a(kick_a), .kick_b(kick_b),
        .irq_lines(irq_lines)
    );

    dma_channel_register_block_checker #(.NCH(NCH)) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .offset(offset), .access_size(access_size),
        .write_data(write_data), .done_channel(done_channel),
        .done_buffer_b(done_buffer_b), .claim_a(claim_a), .claim_b(claim_b),
        .done(done), .read_data(read_data), .access_error(access_error),
        .kick_channel(kick_channel), .kick_a(kick_a), .kick_b(kick_b),
        .irq_lines(irq_lines), .fail_count(fail_count), .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Start stays high across back-to-back words; it drops only for an idle gap.
    task automatic issue_word(input logic [1:0] rq, input logic [7:0] off,
                              input logic [1:0] sz, input logic [31:0] wd,
                              input logic [2:0] dch, input logic dbuf,
                              input logic ca, input logic cb);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req_type <= rq;
        offset <= off;
        access_size <= sz;
        write_data <= wd;
        done_channel <= dch;
        done_buffer_b <= dbuf;
        claim_a <= ca;
        claim_b <= cb;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 && waited < 200)
        begin
            @(negedge clk);
            waited++;
        end
        @(posedge clk);
    endtask

    function automatic logic [1:0] lane_bits(input logic [1:0] sz);
        if (sz == SIZE_BYTE)
            return 2'($urandom_range(0, 3));
        if (sz == SIZE_HALF)
            return ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3))
                                               : {1'($urandom_range(0, 1)), 1'b0};
        return ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
    endfunction

    initial
    begin
        int          pick;
        logic [1:0]  rq;
        logic [7:0]  off;
        logic [1:0]  sz;
        logic [31:0] wd;
        logic [2:0]  dch;
        logic [2:0]  ch;
        logic [2:0]  ridx;
        logic        dbuf;
        logic        ca;
        logic        cb;

        rst_n = 1'b0;
        start = 1'b0;
        req_type = '0;
        offset = '0;
        access_size = '0;
        write_data = '0;
        done_channel = '0;
        done_buffer_b = 1'b0;
        claim_a = 1'b0;
        claim_b = 1'b0;
        gapless = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: field extremes, every request kind and the corner cases.
        issue_word(REQ_READ, 8'h0C, SIZE_WORD, 32'h0, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_WRITE, 8'h00, SIZE_WORD, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1, 1'b1);
        issue_word(REQ_READ, 8'h03, SIZE_BYTE, 32'h0, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_READ, 8'h02, SIZE_HALF, 32'h0, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_WRITE, 8'h31, SIZE_BYTE, 32'h1234_56A5, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_READ, 8'h30, SIZE_WORD, 32'h0, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_WRITE, 8'hBE, SIZE_HALF, 32'h0000_FFFF, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_READ, 8'hBC, SIZE_WORD, 32'h0, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_WRITE, 8'h21, SIZE_WORD, 32'hDEAD_BEEF, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_READ, 8'h21, SIZE_WORD, 32'h0, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_WRITE, 8'h20, SIZE_RSVD, 32'hCAFE_F00D, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_READ, 8'h20, SIZE_RSVD, 32'h0, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_WRITE, 8'hC0, SIZE_WORD, 32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_READ, 8'hFF, SIZE_BYTE, 32'h0, 3'd0, 1'b0, 1'b0, 1'b0);
        // Starts pend without RUN, then a rising RUN offers both buffers.
        issue_word(REQ_WRITE, 8'h44, SIZE_WORD, 32'h0000_0052, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_WRITE, 8'h44, SIZE_WORD, 32'h0000_0001, 3'd0, 1'b0, 1'b1, 1'b0);
        issue_word(REQ_WRITE, 8'h44, SIZE_WORD, 32'h0000_0010, 3'd0, 1'b0, 1'b1, 1'b1);
        issue_word(REQ_DONE, 8'h00, SIZE_BYTE, 32'h0, 3'd2, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_WRITE, 8'h44, SIZE_WORD, 32'h0000_0010, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_DONE, 8'h00, SIZE_BYTE, 32'h0, 3'd6, 1'b1, 1'b0, 1'b0);
        issue_word(REQ_DONE, 8'hFF, SIZE_RSVD, 32'hFFFF_FFFF, 3'd7, 1'b0, 1'b1, 1'b1);
        issue_word(REQ_NOP, 8'h44, SIZE_WORD, 32'hFFFF_FFFF, 3'd2, 1'b1, 1'b1, 1'b1);
        // Channel 0 is a receive channel: an unclaimed offer leaves done clear.
        issue_word(REQ_WRITE, 8'h04, SIZE_WORD, 32'h0000_0013, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_READ, 8'h0C, SIZE_WORD, 32'h0, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_WRITE, 8'h08, SIZE_WORD, 32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_WRITE, 8'h64, SIZE_BYTE, 32'hFFFF_FF51, 3'd0, 1'b0, 1'b1, 1'b0);
        issue_word(REQ_WRITE, 8'h84, SIZE_WORD, 32'h0000_0006, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_WRITE, 8'h8C, SIZE_WORD, 32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 1'b0);
        issue_word(REQ_DONE, 8'h00, SIZE_BYTE, 32'h0, 3'd5, 1'b1, 1'b0, 1'b0);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            gapless = ((i / 150) % 3) == 1;
            if (i == RANDOM_WORDS / 2)
                drain_results();
            rq = 2'($urandom_range(0, 3));
            sz = 2'($urandom_range(0, 3));
            wd = $urandom();
            dch = 3'($urandom_range(0, 7));
            dbuf = 1'($urandom_range(0, 1));
            ca = 1'($urandom_range(0, 1));
            cb = 1'($urandom_range(0, 1));
            off = 8'($urandom_range(0, 255));
            ch = 3'($urandom_range(0, NCH - 1));
            ridx = 3'($urandom_range(0, 7));
            pick = $urandom_range(0, 99);
            if (pick >= 10 && pick < 35)
            begin
                rq = REQ_READ;
                off = {ch, ridx, lane_bits(sz)};
            end
            else if (pick >= 35 && pick < 55)
            begin
                rq = REQ_WRITE;
                case ($urandom_range(0, 4))
                    0: ridx = RIDX_DEVADDR;
                    1: ridx = RIDX_SA_A;
                    2: ridx = RIDX_CNT_A;
                    3: ridx = RIDX_SA_B;
                    default: ridx = RIDX_CNT_B;
                endcase
                off = {ch, ridx, lane_bits(sz)};
            end
            else if (pick >= 55 && pick < 77)
            begin
                // Control words mostly carry only the defined bits.
                rq = REQ_WRITE;
                if ($urandom_range(0, 3) != 0)
                begin
                    sz = SIZE_WORD;
                    wd = 32'($urandom_range(0, 127));
                end
                off = {ch, RIDX_SET, lane_bits(sz)};
            end
            else if (pick >= 77 && pick < 86)
            begin
                rq = REQ_WRITE;
                if ($urandom_range(0, 3) != 0)
                begin
                    sz = SIZE_WORD;
                    wd = 32'($urandom_range(0, 127));
                end
                off = {ch, RIDX_CLR, lane_bits(sz)};
            end
            else if (pick >= 86)
            begin
                rq = REQ_DONE;
                dch = ch;
            end
            issue_word(rq, off, sz, wd, dch, dbuf, ca, cb);
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
